// File: design/lkhp_pkg.sv
`timescale 1ns / 1ps
// Package for the LRU-K history promotion block: field widths, register
// indexes, the per-request operation code and the cell control struct.
package lkhp_pkg;

   // Fixed field widths of the request, response and register channels
   localparam int FIELD_W      = 32;
   localparam int COUNT_W      = 16;
   localparam int FILL_W       = 5;
   localparam int CAP_REG_W    = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 80;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 2'd1;

   // Register reset values
   localparam logic [COUNT_W-1:0]   THRESHOLD_RESET = 16'd2;
   localparam logic [CAP_REG_W-1:0] CAPACITY_RESET  = 5'd16;

   // What one request does; the code is also the outcome field
   typedef enum logic [1:0] {
      OP_APPEND      = 2'd0,
      OP_DROP_OLDEST = 2'd1,
      OP_RAISE       = 2'd2,
      OP_PROMOTE     = 2'd3
   } op_type;

   // Broadcast control for the history cell row
   typedef struct packed {
      logic   compare;   // compare pass: capture match and prefix flags
      logic   update;    // update pass: shift, load or count up
      op_type op;        // operation applied during the update pass
   } cell_ctrl_type;

endpackage

// File: design/lkhp_cell.sv
`timescale 1ns / 1ps
// One history cell: holds a key and its hit count, compares against the
// broadcast key and shifts toward the oldest end. Depends on lkhp_pkg.
module lkhp_cell #(
   parameter int IDX      = 0,
   parameter int KEY_BITS = 32,
   parameter int OCC_W    = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lkhp_pkg::cell_ctrl_type      ctrl,
   input  logic [OCC_W-1:0]             occ,
   input  logic [KEY_BITS-1:0]          key_in,
   input  logic [KEY_BITS-1:0]          nbr_key_in,
   input  logic [lkhp_pkg::COUNT_W-1:0] nbr_cnt_in,
   input  logic                         seen_in,
   input  logic [lkhp_pkg::COUNT_W-1:0] found_cnt_in,
   output logic [KEY_BITS-1:0]          key_out,
   output logic [lkhp_pkg::COUNT_W-1:0] cnt_out,
   output logic                         seen_out,
   output logic [lkhp_pkg::COUNT_W-1:0] found_cnt_out
);
   import lkhp_pkg::*;

   localparam logic [OCC_W-1:0] POS      = OCC_W'(IDX);
   localparam logic [OCC_W-1:0] POS_NEXT = OCC_W'(IDX + 1);

   logic [KEY_BITS-1:0] key_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                match_ff;
   logic                seen_ff;
   logic                live;
   logic                match;
   logic                below_tail;
   logic                at_tail;
   logic                at_occ;

   // Position of this cell against the current fill
   assign live       = POS < occ;
   assign below_tail = POS_NEXT < occ;
   assign at_tail    = POS_NEXT == occ;
   assign at_occ     = POS == occ;

   // Compare and pass the prefix flag and found count to the younger side
   assign match         = live && (key_ff == key_in);
   assign seen_out      = seen_in | match;
   assign found_cnt_out = found_cnt_in | (match ? cnt_ff : '0);
   assign key_out       = key_ff;
   assign cnt_out       = cnt_ff;

   // Flags from the compare pass
   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (ctrl.compare) begin
         match_ff <= match;
         seen_ff  <= seen_out;
      end
   end

   // Entry storage: shift from the younger neighbor, load or count up
   always_ff @(posedge clock) begin
      if (ctrl.update) begin
         case (ctrl.op)
            OP_APPEND: begin
               if (at_occ) begin
                  key_ff <= key_in;
                  cnt_ff <= COUNT_W'(1);
               end
            end
            OP_DROP_OLDEST: begin
               if (below_tail) begin
                  key_ff <= nbr_key_in;
                  cnt_ff <= nbr_cnt_in;
               end else if (at_tail) begin
                  key_ff <= key_in;
                  cnt_ff <= COUNT_W'(1);
               end
            end
            OP_RAISE: begin
               if (match_ff) begin
                  cnt_ff <= cnt_ff + COUNT_W'(1);
               end
            end
            OP_PROMOTE: begin
               if (seen_ff && below_tail) begin
                  key_ff <= nbr_key_in;
                  cnt_ff <= nbr_cnt_in;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: design/lru_k_history_promotion_top.sv
`timescale 1ns / 1ps
// Response: registered by the update pass, which waits while a prior rsp is stalled.
// Requests are taken one at a time: a compare pass over the history cell
// row, then an update pass that shifts, loads or counts in the row and the cache FIFO.
// Reset: clears both fills, the cache head, the FSM and the response valid; sets
// the threshold to 2 and capacity to 16. Key storage is not cleared (no clear pass).
module lru_k_history_promotion_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: access_key [31:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lkhp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // response: outcome [1:0], dropped_history_key [33:2], cache_dropped [34],
   // dropped_cache_key [66:35], history_fill [71:67], cache_fill [76:72]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lkhp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lkhp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lkhp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lkhp_pkg::*;

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CAP_W = (OCC_W > CAP_REG_W) ? OCC_W : CAP_REG_W;
   localparam int SUM_W = OCC_W + 1;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   thr_ff;
   logic [CAP_REG_W-1:0] cap_ff;
   logic [OCC_W-1:0]     hist_occ_ff;
   logic [OCC_W-1:0]     hist_occ_in;
   logic [OCC_W-1:0]     cache_occ_ff;
   logic [OCC_W-1:0]     cache_occ_in;
   logic [IDX_W-1:0]     cache_head_ff;
   logic [IDX_W-1:0]     cache_head_in;
   logic [KEY_BITS-1:0]  key_hold_ff;
   logic                 hit_ff;
   logic [COUNT_W-1:0]   found_cnt_ff;
   logic [KEY_BITS-1:0]  cache_rd_ff;
   logic                 rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   logic [KEY_BITS-1:0]  cache_mem [QUEUE_DEPTH];

   logic                 req_fire;
   logic                 upd_fire;
   logic [KEY_BITS-1:0]  req_key;
   logic [KEY_BITS-1:0]  cell_key;
   cell_ctrl_type        cell_ctrl;
   op_type               op_sel;
   logic [CAP_W-1:0]     cap_ext;
   logic [CAP_W-1:0]     cap_eff;
   logic                 hist_full;
   logic                 cache_full;
   logic                 promote_now;
   logic                 cache_drop;
   logic [SUM_W-1:0]     tail_sum;
   logic [IDX_W-1:0]     tail_idx;
   logic [FIELD_W-1:0]   dropped_hist;
   logic [FIELD_W-1:0]   dropped_cache;

   logic                 seen_chain [QUEUE_DEPTH + 1];
   logic [COUNT_W-1:0]   cnt_chain  [QUEUE_DEPTH + 1];
   logic [KEY_BITS-1:0]  key_row    [QUEUE_DEPTH];
   logic [COUNT_W-1:0]   cnt_row    [QUEUE_DEPTH];

   // Handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign upd_fire   = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Key as stored: low KEY_BITS bits of the request
   assign req_key  = KEY_BITS'(req_tdata[FIELD_W-1:0]);
   assign cell_key = req_fire ? req_key : key_hold_ff;

   // Effective capacity: zero acts as one, clipped to the built depth
   assign cap_ext = CAP_W'(cap_ff);
   always_comb begin
      if (cap_ext == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ext > CAP_W'(QUEUE_DEPTH)) begin
         cap_eff = CAP_W'(QUEUE_DEPTH);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // Operation for the request in flight
   assign hist_full   = CAP_W'(hist_occ_ff) >= cap_eff;
   assign cache_full  = CAP_W'(cache_occ_ff) >= cap_eff;
   assign promote_now = ({1'b0, found_cnt_ff} + 17'd1) >= {1'b0, thr_ff};
   always_comb begin
      if (!hit_ff) begin
         op_sel = hist_full ? OP_DROP_OLDEST : OP_APPEND;
      end else begin
         op_sel = promote_now ? OP_PROMOTE : OP_RAISE;
      end
   end
   assign cache_drop = (op_sel == OP_PROMOTE) && cache_full;

   // Next fills and cache head
   always_comb begin
      hist_occ_in   = hist_occ_ff;
      cache_occ_in  = cache_occ_ff;
      cache_head_in = cache_head_ff;
      case (op_sel)
         OP_APPEND:      hist_occ_in = hist_occ_ff + OCC_W'(1);
         OP_DROP_OLDEST: hist_occ_in = hist_occ_ff;
         OP_RAISE:       hist_occ_in = hist_occ_ff;
         OP_PROMOTE: begin
            hist_occ_in = hist_occ_ff - OCC_W'(1);
            if (cache_full) begin
               if (cache_head_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
                  cache_head_in = '0;
               end else begin
                  cache_head_in = cache_head_ff + IDX_W'(1);
               end
            end else begin
               cache_occ_in = cache_occ_ff + OCC_W'(1);
            end
         end
         default: hist_occ_in = hist_occ_ff;
      endcase
   end

   // Cache write slot: head plus fill, wrapped once
   assign tail_sum = SUM_W'(cache_head_ff) + SUM_W'(cache_occ_ff);
   always_comb begin
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_idx = IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail_idx = IDX_W'(tail_sum);
      end
   end

   // Response fields
   assign dropped_hist  = (op_sel == OP_DROP_OLDEST) ? FIELD_W'(key_row[0]) : '0;
   assign dropped_cache = cache_drop ? FIELD_W'(cache_rd_ff) : '0;
   assign rsp_data_in   = {3'b000,
                           FILL_W'(cache_occ_in),
                           FILL_W'(hist_occ_in),
                           dropped_cache,
                           cache_drop,
                           dropped_hist,
                           op_sel};

   // History cell row
   assign cell_ctrl.compare = req_fire;
   assign cell_ctrl.update  = upd_fire;
   assign cell_ctrl.op      = op_sel;
   assign seen_chain[0]     = 1'b0;
   assign cnt_chain[0]      = '0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0] nbr_key;
      logic [COUNT_W-1:0]  nbr_cnt;
      if (g + 1 < QUEUE_DEPTH) begin : g_mid
         assign nbr_key = key_row[g + 1];
         assign nbr_cnt = cnt_row[g + 1];
      end else begin : g_end
         assign nbr_key = cell_key;
         assign nbr_cnt = COUNT_W'(1);
      end
      lkhp_cell #(
         .IDX      (g),
         .KEY_BITS (KEY_BITS),
         .OCC_W    (OCC_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (cell_ctrl),
         .occ           (hist_occ_ff),
         .key_in        (cell_key),
         .nbr_key_in    (nbr_key),
         .nbr_cnt_in    (nbr_cnt),
         .seen_in       (seen_chain[g]),
         .found_cnt_in  (cnt_chain[g]),
         .key_out       (key_row[g]),
         .cnt_out       (cnt_row[g]),
         .seen_out      (seen_chain[g + 1]),
         .found_cnt_out (cnt_chain[g + 1])
      );
   end

   // Cache FIFO memory: head read at accept, tail written on promotion
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cache_rd_ff <= cache_mem[cache_head_ff];
      end
      if (upd_fire && (op_sel == OP_PROMOTE)) begin
         cache_mem[tail_idx] <= key_hold_ff;
      end
   end

   // Control FSM, registers and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         thr_ff        <= THRESHOLD_RESET;
         cap_ff        <= CAPACITY_RESET;
         hist_occ_ff   <= '0;
         cache_occ_ff  <= '0;
         cache_head_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff <= csr_data;
               CSR_CAPACITY:  cap_ff <= csr_data[CAP_REG_W-1:0];
               default: begin
               end
            endcase
         end
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  key_hold_ff  <= req_key;
                  hit_ff       <= seen_chain[QUEUE_DEPTH];
                  found_cnt_ff <= cnt_chain[QUEUE_DEPTH];
                  state_ff     <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (upd_fire) begin
                  hist_occ_ff   <= hist_occ_in;
                  cache_occ_ff  <= cache_occ_in;
                  cache_head_ff <= cache_head_in;
                  rsp_data_ff   <= rsp_data_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (hist_occ_ff <= OCC_W'(QUEUE_DEPTH)) && (cache_occ_ff <= OCC_W'(QUEUE_DEPTH)))
      else $error("queue fill above built depth");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upd_fire))
      else $error("response raised without an update pass");

   a_cache_drop_promote: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[34]) |-> (rsp_data_ff[1:0] == OP_PROMOTE))
      else $error("cache drop without promotion");

   a_raise_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && (op_sel == OP_RAISE)) |=> $stable(hist_occ_ff))
      else $error("count raise changed history fill");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_k_history_promotion_top: a directed table, then random
// access streams over several threshold/capacity settings and idling mixes.
// Depends on lkhp_pkg for widths, register indexes and the outcome enum.
module testbench;
   import lkhp_pkg::*;

   localparam int QUEUE_DEPTH       = 16;
   localparam int KEY_BITS          = 32;
   localparam int ITEMS_PER_SETTING = 140;
   localparam int LIMIT_CYCLES      = 400000;
   localparam int POOL_SIZE         = 20;

   // Response layout, lowest bit last
   typedef struct packed {
      logic [2:0]         pad;
      logic [FILL_W-1:0]  cache_fill;
      logic [FILL_W-1:0]  history_fill;
      logic [FIELD_W-1:0] dropped_cache_key;
      logic               cache_dropped;
      logic [FIELD_W-1:0] dropped_history_key;
      op_type             outcome;
   } access_result_t;

   // One row of the directed table: a register write or an access
   typedef struct {
      bit                     is_reg;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      logic [FIELD_W-1:0]     key;
      bit                     typed;
      access_result_t         want;
   } stim_row_t;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // access_key [31:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // outcome [1:0], dropped_history_key [33:2], cache_dropped [34],
   // dropped_cache_key [66:35], history_fill [71:67], cache_fill [76:72]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Predictor state
   logic [FIELD_W-1:0]   hist_key   [QUEUE_DEPTH];
   logic [COUNT_W-1:0]   hist_count [QUEUE_DEPTH];
   int                   hist_fill  = 0;
   logic [FIELD_W-1:0]   fifo_key   [QUEUE_DEPTH];
   int                   fifo_head  = 0;
   int                   fifo_fill  = 0;
   logic [COUNT_W-1:0]   shadow_threshold = THRESHOLD_RESET;
   logic [CAP_REG_W-1:0] shadow_capacity  = CAPACITY_RESET;

   access_result_t pending_results [$];
   stim_row_t      directed_rows [$];
   int             mismatch_count = 0;
   int             cycle_count    = 0;
   int             send_idle      = 14;
   int             recv_idle      = 67;

   // Register settings for the random part, four per idling mix
   int thr_list [12] = '{2, 1, 3, 65535, 0, 4, 2, 5, 3, 2, 6, 3};
   int cap_list [12] = '{16, 1, 4, 16, 31, 0, 2, 8, 17, 3, 16, 5};

   lru_k_history_promotion_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .KEY_BITS   (KEY_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int effective_capacity();
      if (shadow_capacity == 0) return 1;
      if (shadow_capacity > QUEUE_DEPTH) return QUEUE_DEPTH;
      return int'(shadow_capacity);
   endfunction

   // Remove a history entry; later entries close up
   function automatic void drop_history_entry(int pos);
      for (int i = pos; i + 1 < hist_fill; i++) begin
         hist_key[i]   = hist_key[i + 1];
         hist_count[i] = hist_count[i + 1];
      end
      hist_fill--;
   endfunction

   // Work out the response to one access and advance the predictor state
   function automatic access_result_t predict_access(logic [FIELD_W-1:0] key);
      access_result_t r;
      int             cap;
      int             pos;
      bit             hit;
      r   = '0;
      cap = effective_capacity();
      pos = 0;
      hit = 1'b0;
      for (int i = 0; i < hist_fill; i++) begin
         if (!hit && hist_key[i] == key) begin
            hit = 1'b1;
            pos = i;
         end
      end
      r.outcome = OP_APPEND;
      if (!hit) begin
         // miss: make room if full, then append with one hit
         if (hist_fill >= cap) begin
            r.dropped_history_key = hist_key[0];
            drop_history_entry(0);
            r.outcome = OP_DROP_OLDEST;
         end
         if (hist_fill < QUEUE_DEPTH) begin
            hist_key[hist_fill]   = key;
            hist_count[hist_fill] = COUNT_W'(1);
            hist_fill++;
         end
      end else if (int'(hist_count[pos]) + 1 < int'(shadow_threshold)) begin
         hist_count[pos] = hist_count[pos] + 1'b1;
         r.outcome = OP_RAISE;
      end else begin
         // promotion: leave the history, push into the cache FIFO
         drop_history_entry(pos);
         r.outcome = OP_PROMOTE;
         if (fifo_fill >= cap) begin
            r.dropped_cache_key = fifo_key[fifo_head];
            r.cache_dropped     = 1'b1;
            fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
            fifo_fill--;
         end
         fifo_key[(fifo_head + fifo_fill) % QUEUE_DEPTH] = key;
         fifo_fill++;
      end
      r.history_fill = hist_fill[FILL_W-1:0];
      r.cache_fill   = fifo_fill[FILL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                              input logic [FIELD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Directed table builders
   task automatic add_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      stim_row_t row;
      row           = '{default: '0};
      row.is_reg    = 1'b1;
      row.reg_index = idx;
      row.reg_value = val;
      directed_rows.push_back(row);
   endtask

   task automatic add_access(input logic [FIELD_W-1:0] key);
      stim_row_t row;
      row     = '{default: '0};
      row.key = key;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [FIELD_W-1:0] key, input op_type op,
                            input logic [FIELD_W-1:0] dhk, input logic cd,
                            input logic [FIELD_W-1:0] dck, input logic [FILL_W-1:0] hf,
                            input logic [FILL_W-1:0] cf);
      stim_row_t row;
      row       = '{default: '0};
      row.key   = key;
      row.typed = 1'b1;
      row.want  = '{3'b000, cf, hf, dck, cd, dhk, op};
      directed_rows.push_back(row);
   endtask

   // Register write; hold keeps csr_valid up for a write that follows at once
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val, input bit hold);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_THRESHOLD) shadow_threshold = val;
      else if (idx == CSR_CAPACITY) shadow_capacity = val[CAP_REG_W-1:0];
      @(negedge clock);
      if (!hold) csr_valid <= 1'b0;
   endtask

   // One access request; last drops req_tvalid after the handshake
   task automatic send_access(input logic [FIELD_W-1:0] key, input bit last,
                              input bit typed, input access_result_t want);
      access_result_t predicted;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      predicted = predict_access(key);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
      if (last) req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // Response checker and cycle limit
   always @(posedge clock) begin
      access_result_t got;
      access_result_t want;
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = access_result_t'(rsp_tdata);
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending: %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            check_field("outcome", 32'(got.outcome), 32'(want.outcome));
            check_field("dropped_history_key", got.dropped_history_key,
                        want.dropped_history_key);
            check_field("cache_dropped", 32'(got.cache_dropped), 32'(want.cache_dropped));
            check_field("dropped_cache_key", got.dropped_cache_key, want.dropped_cache_key);
            check_field("history_fill", 32'(got.history_fill), 32'(want.history_fill));
            check_field("cache_fill", 32'(got.cache_fill), 32'(want.cache_fill));
            check_field("pad", 32'(got.pad), 32'(want.pad));
         end
      end
   end

   // Stimulus
   initial begin
      logic [FIELD_W-1:0] key_pool [POOL_SIZE];
      logic [FIELD_W-1:0] key;
      int                 pool_size;
      bit                 next_is_reg;
      stim_row_t          row;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset: threshold 2, capacity 16
      add_typed(32'h0000_0000, OP_APPEND,  '0, 1'b0, '0, 5'd1, 5'd0);
      add_typed(32'h0000_0000, OP_PROMOTE, '0, 1'b0, '0, 5'd0, 5'd1);
      add_typed(32'h7FFF_FFFF, OP_APPEND,  '0, 1'b0, '0, 5'd1, 5'd1);
      add_typed(32'h8000_0000, OP_APPEND,  '0, 1'b0, '0, 5'd2, 5'd1);
      add_typed(32'hFFFF_FFFF, OP_APPEND,  '0, 1'b0, '0, 5'd3, 5'd1);
      add_typed(32'h8000_0000, OP_PROMOTE, '0, 1'b0, '0, 5'd2, 5'd2);
      // capacity lowered to the current fill: both queues now full
      add_reg(CSR_CAPACITY, 16'd2);
      add_typed(32'h0000_0005, OP_DROP_OLDEST, 32'h7FFF_FFFF, 1'b0, '0, 5'd2, 5'd2);
      add_typed(32'h0000_0005, OP_PROMOTE, '0, 1'b1, 32'h0000_0000, 5'd1, 5'd2);
      // threshold zero: any hit promotes
      add_reg(CSR_THRESHOLD, 16'd0);
      add_typed(32'hFFFF_FFFF, OP_PROMOTE, '0, 1'b1, 32'h8000_0000, 5'd0, 5'd2);
      // top threshold: hits only count up
      add_reg(CSR_THRESHOLD, 16'hFFFF);
      add_typed(32'h0000_0009, OP_APPEND, '0, 1'b0, '0, 5'd1, 5'd2);
      add_typed(32'h0000_0009, OP_RAISE,  '0, 1'b0, '0, 5'd1, 5'd2);
      add_typed(32'h0000_0009, OP_RAISE,  '0, 1'b0, '0, 5'd1, 5'd2);
      // capacity zero acts as one
      add_reg(CSR_CAPACITY, 16'd0);
      add_typed(32'h0000_000A, OP_DROP_OLDEST, 32'h0000_0009, 1'b0, '0, 5'd1, 5'd2);
      // threshold one; cache over capacity drops one and keeps its fill
      add_reg(CSR_THRESHOLD, 16'd1);
      add_typed(32'h0000_000A, OP_PROMOTE, '0, 1'b1, 32'h0000_0005, 5'd0, 5'd2);
      // capacity above depth (upper data bits set too), threshold three
      add_reg(CSR_CAPACITY, 16'hFFF1);
      add_reg(CSR_THRESHOLD, 16'd3);
      add_access(32'hAAAA_AAAA);
      add_access(32'h5555_5555);
      add_access(32'hAAAA_AAAA);
      add_access(32'hAAAA_AAAA);

      // Walk the table
      for (int i = 0; i < directed_rows.size(); i++) begin
         row         = directed_rows[i];
         next_is_reg = (i + 1 < directed_rows.size()) && directed_rows[i + 1].is_reg;
         if (row.is_reg) begin
            drain_results();
            write_reg(row.reg_index, row.reg_value, next_is_reg);
         end else begin
            send_access(row.key, next_is_reg || (i + 1 == directed_rows.size()),
                        row.typed, row.want);
         end
      end

      // Random part: three idling mixes, four register settings each
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 14 : (phase == 1) ? 67 : 0;
         recv_idle = (phase == 0) ? 67 : (phase == 1) ? 14 : 0;
         for (int s = 0; s < 4; s++) begin
            drain_results();
            write_reg(CSR_THRESHOLD, CSR_DATA_W'(thr_list[phase * 4 + s]), 1'b1);
            write_reg(CSR_CAPACITY, CSR_DATA_W'(cap_list[phase * 4 + s]), 1'b0);
            // a small key pool so that hits, raises and promotions recur
            pool_size = $urandom_range(1, effective_capacity() + 4);
            foreach (key_pool[k]) key_pool[k] = $urandom;
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               if ($urandom_range(0, 99) < 85)
                  key = key_pool[$urandom_range(0, pool_size - 1)];
               else
                  key = $urandom;
               send_access(key, n == ITEMS_PER_SETTING - 1, 1'b0, '0);
            end
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
design/lkhp_pkg.sv
design/lkhp_cell.sv
design/lru_k_history_promotion_top.sv
tb/testbench.sv
